/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg
// Types and constants of the periodic topic scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 31;
  localparam int unsigned TOPIC_W  = 8;

  // Input command codes
  typedef enum logic [1:0] {
    KIND_SUBSCRIBE   = 2'd0,
    KIND_UNSUBSCRIBE = 2'd1,
    KIND_UNKNOWN     = 2'd2,
    KIND_TICK        = 2'd3
  } kind_e;

  // Result kinds
  localparam logic RES_ACK = 1'b0;
  localparam logic RES_DUE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_CMP,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  // Table write controls
  typedef struct packed {
    logic subscribe;
    logic unsubscribe;
    logic fire;
  } tbl_wr_t;

endpackage

`default_nettype wire

/* rtl/core/pts_table.sv */
// ----------------------------------------------------------------------------
// pts_table
// Subscription table: enable flags in flops, period and fired time in memory.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_table #(
  parameter int unsigned TOPICS = 16,
  parameter int unsigned IDX_W  = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pts_pkg::tbl_wr_t              wr_i,
  input  wire logic [IDX_W-1:0]              wr_addr_i,
  input  wire logic [pts_pkg::PERIOD_W-1:0]  period_i,
  input  wire logic [pts_pkg::TIME_W-1:0]    now_i,
  input  wire logic [IDX_W-1:0]              rd_addr_i,
  output logic                               rd_en_o,
  output logic [pts_pkg::PERIOD_W-1:0]       rd_period_o,
  output logic [pts_pkg::TIME_W-1:0]         rd_fired_o
);

  logic [TOPICS-1:0]                 en_q;
  // Period and fired time only matter once subscribe has written them,
  // since enable is set by that same write.
  logic [pts_pkg::PERIOD_W-1:0]      period_mem [TOPICS];
  logic [pts_pkg::TIME_W-1:0]        fired_mem  [TOPICS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else if (wr_i.subscribe) begin
      en_q[wr_addr_i] <= 1'b1;
    end else if (wr_i.unsubscribe) begin
      en_q[wr_addr_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.subscribe) begin
      period_mem[wr_addr_i] <= period_i;
      fired_mem[wr_addr_i]  <= '0;
    end else if (wr_i.fire) begin
      fired_mem[wr_addr_i]  <= now_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_period_o <= period_mem[rd_addr_i];
    rd_fired_o  <= fired_mem[rd_addr_i];
  end

  assign rd_en_o = en_q[rd_addr_i];

endmodule

`default_nettype wire

/* rtl/core/periodic_topic_scheduler_top.sv */
// ----------------------------------------------------------------------------
// periodic_topic_scheduler_top
// Subscription table with periodic due-topic scan on each millisecond tick.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries subscribe, unsubscribe,
//    unknown-command and tick transactions; output channel (out_valid_o /
//    out_stall_i) returns acknowledges and due-topic results.
//  - Commands: one ack, registered the cycle after acceptance, last_o set.
//    ok_o is 1 only for a known command with topic below TOPICS.
//  - Tick: entries scanned in index order by one shared 33-bit subtractor,
//    used twice per enabled entry (elapsed time, then compare with period).
//    A disabled entry passes only the read step, an enabled one read,
//    difference and compare, plus an emit step per due topic after the
//    first and a flush step if any was due.
//  - Due results trail the scan by one entry so the final one can carry
//    last_o; a tick with nothing due gives no transaction at all.
//  - The input stalls for the whole scan, and while an ack cannot be placed
//    because the output register is full and stalled.
//  - A stalled receiver holds the output register; the scan waits for it.
//  - Reset clears all enable flags and the sequencer; the period and
//    fired-time memories need no clearing since enable guards them.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_topic_scheduler_top #(
  parameter int unsigned TOPICS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [pts_pkg::TOPIC_W-1:0]   topic_i,
  input  wire logic [pts_pkg::PERIOD_W-1:0]  period_ms_i,
  input  wire logic [pts_pkg::TIME_W-1:0]    now_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               result_kind_o,
  output logic                               ok_o,
  output logic [pts_pkg::TOPIC_W-1:0]        due_topic_o,
  output logic                               last_o
);

  localparam int unsigned IDX_W = (TOPICS > 1) ? $clog2(TOPICS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOPICS - 1);

  pts_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic [pts_pkg::TIME_W-1:0]       now_q;
  logic [pts_pkg::TIME_W-1:0]       diff_q;
  logic                             pend_valid_q, pend_valid_d;
  logic [pts_pkg::TOPIC_W-1:0]      pend_topic_q, pend_topic_d;

  logic                             out_valid_q;
  logic                             out_kind_q, out_ok_q, out_last_q;
  logic [pts_pkg::TOPIC_W-1:0]      out_topic_q;

  logic                             out_load;
  logic                             ld_kind, ld_ok, ld_last;
  logic [pts_pkg::TOPIC_W-1:0]      ld_topic;

  logic                             in_acc, out_free, at_last, adv, due, topic_ok;

  pts_pkg::tbl_wr_t                 tbl_wr;
  logic [IDX_W-1:0]                 tbl_wr_addr;
  logic                             rd_en;
  logic [pts_pkg::PERIOD_W-1:0]     rd_period;
  logic [pts_pkg::TIME_W-1:0]       rd_fired;

  // Shared subtractor
  logic [pts_pkg::TIME_W:0]         sub_a, sub_b, sub_res;

  assign in_stall_o = (state_q != pts_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign at_last    = (idx_q == LAST_IDX);
  assign topic_ok   = ({1'b0, topic_i} < (pts_pkg::TOPIC_W + 1)'(TOPICS));

  // ST_DIFF: elapsed = now - fired.  ST_CMP: period - elapsed borrows when due.
  always_comb begin
    if (state_q == pts_pkg::ST_DIFF) begin
      sub_a = {1'b0, now_q};
      sub_b = {1'b0, rd_fired};
    end else begin
      sub_a = {2'b00, rd_period};
      sub_b = {1'b0, diff_q};
    end
  end

  assign sub_res = sub_a - sub_b;
  // Negative elapsed time is never due
  assign due     = !diff_q[pts_pkg::TIME_W-1] && sub_res[pts_pkg::TIME_W];

  pts_table #(
    .TOPICS (TOPICS),
    .IDX_W  (IDX_W)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (tbl_wr),
    .wr_addr_i   (tbl_wr_addr),
    .period_i    (period_ms_i),
    .now_i       (now_q),
    .rd_addr_i   (idx_q),
    .rd_en_o     (rd_en),
    .rd_period_o (rd_period),
    .rd_fired_o  (rd_fired)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_acc && (pts_pkg::kind_e'(kind_i) == pts_pkg::KIND_TICK)) begin
          state_d = pts_pkg::ST_READ;
        end
      end
      pts_pkg::ST_READ:  state_d = rd_en ? pts_pkg::ST_DIFF : pts_pkg::ST_READ;
      pts_pkg::ST_DIFF:  state_d = pts_pkg::ST_CMP;
      pts_pkg::ST_CMP: begin
        if (due && pend_valid_q) begin
          state_d = pts_pkg::ST_EMIT;
        end
      end
      pts_pkg::ST_EMIT:  state_d = state_q;
      pts_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_d = pts_pkg::ST_IDLE;
        end
      end
      default:           state_d = pts_pkg::ST_IDLE;
    endcase
    // Step to the next entry, or finish the scan
    if (adv) begin
      if (!at_last) begin
        state_d = pts_pkg::ST_READ;
      end else if (pend_valid_d) begin
        state_d = pts_pkg::ST_FLUSH;
      end else begin
        state_d = pts_pkg::ST_IDLE;
      end
    end
  end

  // Datapath and table control
  always_comb begin
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_topic_d = pend_topic_q;
    out_load     = 1'b0;
    ld_kind      = pts_pkg::RES_ACK;
    ld_ok        = 1'b0;
    ld_topic     = '0;
    ld_last      = 1'b1;
    tbl_wr       = '0;
    tbl_wr_addr  = idx_q;
    adv          = 1'b0;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_acc) begin
          tbl_wr_addr = topic_i[IDX_W-1:0];
          unique case (pts_pkg::kind_e'(kind_i))
            pts_pkg::KIND_SUBSCRIBE: begin
              tbl_wr.subscribe = topic_ok;
              ld_ok            = topic_ok;
              out_load         = 1'b1;
            end
            pts_pkg::KIND_UNSUBSCRIBE: begin
              tbl_wr.unsubscribe = topic_ok;
              ld_ok              = topic_ok;
              out_load           = 1'b1;
            end
            pts_pkg::KIND_UNKNOWN: begin
              out_load = 1'b1;
            end
            pts_pkg::KIND_TICK: begin
              idx_d        = '0;
              pend_valid_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      pts_pkg::ST_READ: begin
        adv = !rd_en;
      end
      pts_pkg::ST_DIFF: ;
      pts_pkg::ST_CMP: begin
        if (due) begin
          tbl_wr.fire = 1'b1;
          if (!pend_valid_q) begin
            pend_valid_d = 1'b1;
            pend_topic_d = pts_pkg::TOPIC_W'(idx_q);
            adv          = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
      end
      pts_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          ld_kind      = pts_pkg::RES_DUE;
          ld_topic     = pend_topic_q;
          ld_last      = 1'b0;
          pend_topic_d = pts_pkg::TOPIC_W'(idx_q);
          adv          = 1'b1;
        end
      end
      pts_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          ld_kind      = pts_pkg::RES_DUE;
          ld_topic     = pend_topic_q;
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (adv && !at_last) begin
      idx_d = IDX_W'(idx_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pts_pkg::ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    pend_topic_q <= pend_topic_d;
    if (in_acc) begin
      now_q <= now_ms_i;
    end
    if (state_q == pts_pkg::ST_DIFF) begin
      diff_q <= sub_res[pts_pkg::TIME_W-1:0];
    end
    if (out_load) begin
      out_kind_q  <= ld_kind;
      out_ok_q    <= ld_ok;
      out_topic_q <= ld_topic;
      out_last_q  <= ld_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign ok_o          = out_ok_q;
  assign due_topic_o   = out_topic_q;
  assign last_o        = out_last_q;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_pend_only_in_scan,
    !pend_valid_q || (state_q != pts_pkg::ST_IDLE), "pending result outside scan")
  `ASSERT_ALWAYS(a_flush_has_pend,
    (state_q != pts_pkg::ST_FLUSH) || pend_valid_q, "flush without pending result")
  `ASSERT_ALWAYS(a_ack_is_last,
    !out_valid_q || (out_kind_q != pts_pkg::RES_ACK) || (out_last_q && (out_topic_q == '0)),
    "malformed acknowledge")
  `ASSERT_NEXT(a_cmd_acked, in_acc && (kind_i != pts_pkg::KIND_TICK),
    out_valid_o && (result_kind_o == pts_pkg::RES_ACK) && (state_q == pts_pkg::ST_IDLE),
    "command not acknowledged")

endmodule

`default_nettype wire

/* tb/sv/periodic_topic_scheduler_checker.sv */
// ----------------------------------------------------------------------------
// periodic_topic_scheduler_checker
// Watches both channels of the scheduler, keeps its own copy of the
// subscription table and compares every result against the prediction.
// ----------------------------------------------------------------------------
module periodic_topic_scheduler_checker #(
  parameter int unsigned TOPICS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    kind_i,
  input  logic [pts_pkg::TOPIC_W-1:0]   topic_i,
  input  logic [pts_pkg::PERIOD_W-1:0]  period_ms_i,
  input  logic [pts_pkg::TIME_W-1:0]    now_ms_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          result_kind_i,
  input  logic                          ok_i,
  input  logic [pts_pkg::TOPIC_W-1:0]   due_topic_i,
  input  logic                          last_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            ack_count_o,
  output int                            due_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIME_W   = pts_pkg::TIME_W;
  localparam int unsigned PERIOD_W = pts_pkg::PERIOD_W;
  localparam int unsigned TOPIC_W  = pts_pkg::TOPIC_W;

  typedef struct packed {
    logic               kind;
    logic               ok;
    logic [TOPIC_W-1:0] topic;
    logic               last;
  } sched_result_t;

  typedef struct {
    bit                on;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] fired;
  } sub_entry_t;

  sub_entry_t    subs [TOPICS];
  sched_result_t awaited_q [$];

  int fails   = 0;
  int pending = 0;
  int acks    = 0;
  int dues    = 0;
  int seen    = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign ack_count_o  = acks;
  assign due_count_o  = dues;

  task automatic flag_mismatch(string what);
    $display("[%0t] result %0d: %s", $realtime, seen, what);
    fails++;
  endtask

  function automatic sched_result_t make_ack(logic ok);
    sched_result_t r;
    r = '{kind: pts_pkg::RES_ACK, ok: ok, topic: '0, last: 1'b1};
    return r;
  endfunction

  // Table update and expected results for one accepted transaction.
  task automatic apply_command(pts_pkg::kind_e kind, logic [TOPIC_W-1:0] topic,
                               logic [PERIOD_W-1:0] per, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    int                due_idx [$];
    sched_result_t     r;
    case (kind)
      pts_pkg::KIND_SUBSCRIBE: begin
        if (topic < TOPICS) begin
          subs[topic].period = {1'b0, per};
          subs[topic].fired  = '0;
          subs[topic].on     = 1'b1;
        end
        awaited_q.push_back(make_ack(topic < TOPICS));
      end
      pts_pkg::KIND_UNSUBSCRIBE: begin
        if (topic < TOPICS) subs[topic].on = 1'b0;
        awaited_q.push_back(make_ack(topic < TOPICS));
      end
      pts_pkg::KIND_TICK: begin
        for (int i = 0; i < TOPICS; i++) begin
          if (subs[i].on) begin
            elapsed = now - subs[i].fired;
            // negative as signed: interval not yet started
            if (!elapsed[TIME_W-1] && elapsed > subs[i].period) begin
              due_idx.push_back(i);
              subs[i].fired = now;
            end
          end
        end
        foreach (due_idx[j]) begin
          r = '{kind: pts_pkg::RES_DUE, ok: 1'b0, topic: TOPIC_W'(due_idx[j]),
                last: (j == due_idx.size() - 1)};
          awaited_q.push_back(r);
        end
      end
      default: awaited_q.push_back(make_ack(1'b0));
    endcase
  endtask

  task automatic check_result();
    sched_result_t want;
    if (awaited_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind=%0d topic=%0d",
                              result_kind_i, due_topic_i));
    end else begin
      want = awaited_q.pop_front();
      if (result_kind_i !== want.kind)
        flag_mismatch($sformatf("result_kind got %0d want %0d", result_kind_i, want.kind));
      if (ok_i !== want.ok)
        flag_mismatch($sformatf("ok got %0d want %0d", ok_i, want.ok));
      if (due_topic_i !== want.topic)
        flag_mismatch($sformatf("due_topic got %0d want %0d", due_topic_i, want.topic));
      if (last_i !== want.last)
        flag_mismatch($sformatf("last got %0d want %0d", last_i, want.last));
      if (want.kind == pts_pkg::RES_DUE) dues++;
      else acks++;
    end
    seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TOPICS; i++) subs[i] = '{on: 1'b0, period: 32'd1000, fired: '0};
      awaited_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i)
        apply_command(pts_pkg::kind_e'(kind_i), topic_i, period_ms_i, now_ms_i);
      pending = awaited_q.size();
    end
  end

endmodule

/* tb/sv/tb_periodic_topic_scheduler_top.sv */
// ----------------------------------------------------------------------------
// tb_periodic_topic_scheduler_top
// Drives subscribe, unsubscribe, unknown and tick transactions into the
// scheduler with random gaps and output stalls; the checker beside the block
// predicts the acknowledges and due topics and counts any disagreement.
// ----------------------------------------------------------------------------
module tb_periodic_topic_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIME_W   = pts_pkg::TIME_W;
  localparam int unsigned PERIOD_W = pts_pkg::PERIOD_W;
  localparam int unsigned TOPIC_W  = pts_pkg::TOPIC_W;

  localparam int unsigned TOPICS     = 16;
  localparam int          RAND_ITEMS = 200;
  // a full worst-case tick scan with every entry due, plus a margin on top
  localparam int          SETTLE_CYC = 4 * TOPICS + 16;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [1:0]          kind_i      = '0;
  logic [TOPIC_W-1:0]  topic_i     = '0;
  logic [PERIOD_W-1:0] period_ms_i = '0;
  logic [TIME_W-1:0]   now_ms_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                result_kind_o;
  logic                ok_o;
  logic [TOPIC_W-1:0]  due_topic_o;
  logic                last_o;

  int fail_count;
  int pending;
  int ack_count;
  int due_count;

  // transaction tallies for the summary
  int n_cmds  = 0;
  int n_ticks = 0;
  // remaining back-to-back transactions on the sending side
  int send_rush = 0;

  periodic_topic_scheduler_top #(
    .TOPICS(TOPICS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .topic_i      (topic_i),
    .period_ms_i  (period_ms_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .ok_o         (ok_o),
    .due_topic_o  (due_topic_o),
    .last_o       (last_o)
  );

  periodic_topic_scheduler_checker #(
    .TOPICS(TOPICS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .kind_i       (kind_i),
    .topic_i      (topic_i),
    .period_ms_i  (period_ms_i),
    .now_ms_i     (now_ms_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_i(result_kind_o),
    .ok_i         (ok_o),
    .due_topic_i  (due_topic_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .ack_count_o  (ack_count),
    .due_count_o  (due_count)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: well beyond the slowest legal run (every tick scanning a full
  // table with sixteen due topics, each held by a maximal output stall).
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiving side: after each accepted result, keep stall high for a random
  // hold; now and then a run of results goes through with no stall at all.
  initial begin
    int hold;
    int rush;
    hold = 0;
    rush = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (rush > 0) begin
          hold = 0;
          rush--;
        end else begin
          hold = $urandom_range(0, 6);
          if ($urandom_range(0, 14) == 0) rush = $urandom_range(5, 20);
        end
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // One transaction on the input channel. Called at a rising edge; returns at
  // the edge where the transaction is taken, with valid still high so a
  // following transaction can go straight out.
  task automatic send_item(pts_pkg::kind_e kind, logic [TOPIC_W-1:0] topic,
                           logic [PERIOD_W-1:0] per, logic [TIME_W-1:0] now);
    int gap;
    if (send_rush > 0) begin
      gap = 0;
      send_rush--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 14) == 0) send_rush = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    topic_i     <= topic;
    period_ms_i <= per;
    now_ms_i    <= now;
    do @(posedge clk_i); while (in_stall_o);
    if (kind == pts_pkg::KIND_TICK) n_ticks++;
    else n_cmds++;
  endtask

  // Sender holds off until every predicted result has been taken. The count
  // is read at the falling edge, after the checker has updated it.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [TOPIC_W-1:0] pick_topic();
    // mostly a real entry, sometimes anything the 8-bit field can hold
    if ($urandom_range(0, 9) == 0) return TOPIC_W'($urandom);
    return TOPIC_W'($urandom_range(0, TOPICS - 1));
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 19))
      0:       return PERIOD_W'($urandom);
      1:       return '1;
      2:       return '0;
      default: return PERIOD_W'($urandom_range(0, 40));
    endcase
  endfunction

  initial begin
    logic [TIME_W-1:0] sim_ms;
    int                sel;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // tick with an empty table: no transaction back at all
    send_item(pts_pkg::KIND_TICK, 8'hFF, '1, '0);
    // zero period on the first entry, widest period on the last
    send_item(pts_pkg::KIND_SUBSCRIBE, 8'd0, '0, '1);
    send_item(pts_pkg::KIND_SUBSCRIBE, 8'(TOPICS - 1), '1, '0);
    // topic just past the table and at the top of the field: ack with ok low
    send_item(pts_pkg::KIND_SUBSCRIBE, 8'(TOPICS), 31'd5, '0);
    send_item(pts_pkg::KIND_UNSUBSCRIBE, 8'hFF, '0, '0);
    // unrecognised command, every other field at its maximum
    send_item(pts_pkg::KIND_UNKNOWN, 8'hFF, '1, '1);
    // entry 0 fires one tick after its zero period
    send_item(pts_pkg::KIND_TICK, '0, '0, 32'd1);
    // elapsed time negative as signed: nothing due
    send_item(pts_pkg::KIND_TICK, '0, '0, 32'h8000_0001);
    // re-fill the table with zero periods, resubscribing the last entry
    for (int t = 1; t < TOPICS; t++) send_item(pts_pkg::KIND_SUBSCRIBE, 8'(t), '0, '0);
    drain_results();
    // every entry due on one tick: a full burst ending in last
    send_item(pts_pkg::KIND_TICK, '0, '0, 32'h7FFF_FFFF);
    send_item(pts_pkg::KIND_UNSUBSCRIBE, 8'd7, '0, '0);

    // ---- random part ----
    // ticks as the largest share, on a slowly advancing clock so periods really elapse,
    // with jumps (including backwards and across the wrap) as noise
    sim_ms = 32'h7FFF_FFFF;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        case ($urandom_range(0, 19))
          0, 1:    sim_ms = $urandom;
          2:       sim_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
          default: sim_ms = sim_ms + $urandom_range(0, 24);
        endcase
        send_item(pts_pkg::KIND_TICK, TOPIC_W'($urandom), PERIOD_W'($urandom), sim_ms);
      end else if (sel < 72) begin
        send_item(pts_pkg::KIND_SUBSCRIBE, pick_topic(), pick_period(), $urandom);
      end else if (sel < 90) begin
        send_item(pts_pkg::KIND_UNSUBSCRIBE, pick_topic(), PERIOD_W'($urandom), $urandom);
      end else begin
        send_item(pts_pkg::KIND_UNKNOWN, TOPIC_W'($urandom), PERIOD_W'($urandom), $urandom);
      end
      if (n % 50 == 49) drain_results();
    end

    // ---- wind down ----
    drain_results();
    // a final tick with nothing due may still be scanning
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Sent %0d commands and %0d ticks;", n_cmds, n_ticks);
    $display("checked %0d acknowledges and %0d due topics.", ack_count, due_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
